// ----- rtl/tli_pkg.sv -----
// Shared types and codes for the table linear interpolator.
// No dependencies; the top, the front end, the back end and the testbench import this package.
package tli_pkg;

  // Request actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam int CFG_DATA_W = 7;

  typedef struct packed {
    logic               action;
    logic [5:0]         entry_index;
    logic signed [31:0] entry_distance;
    logic [31:0]        entry_redshift;
    logic signed [31:0] position;
  } tli_in_t;

  typedef struct packed {
    logic [31:0] redshift;
    logic        beyond_table;
  } tli_out_t;

  // Query handed from front to back
  typedef struct packed {
    logic signed [31:0] position;
    logic               force_zero;
  } tli_job_t;

endpackage

// ----- rtl/table_linear_interpolator.sv -----
// Timing: a load is written in the cycle it is accepted; an interpolated query
// scans the table for its segment, then multiplies and runs the 64-step divider;
// zero-forced queries skip the scan and the arithmetic.
// Throughput: one query in flight at a time; a two-entry queue buffers queries.
// Reset (synchronous, rst_n low): mode_one_dim = 1, entry_count = 2, queues empty;
// table contents are undefined until loaded.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tli_pkg::tli_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tli_pkg::tli_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [tli_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = $clog2(TABLE_DEPTH + 1);

  logic          mode_r;
  logic [6:0]    count_r;
  logic [KW-1:0] n_cnt;
  logic          back_idle, ram_we, job_valid, job_ready;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;
  tli_job_t      job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      count_r <= 7'd2;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_MODE)  mode_r  <= cfg_wdata[0];
      if (cfg_index == CFG_COUNT) count_r <= cfg_wdata;
    end
  end

  // Entries in use, clamped to the table
  always_comb begin
    if (count_r < 7'd2) begin
      n_cnt = KW'(2);
    end else if (int'(count_r) > TABLE_DEPTH) begin
      n_cnt = KW'(TABLE_DEPTH);
    end else begin
      n_cnt = KW'(count_r);
    end
  end

  tli_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .mode_one_dim (mode_r),
    .back_idle    (back_idle),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job)
  );

  // Distance in the upper half, redshift in the lower
  tli_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  tli_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .n_cnt     (n_cnt),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .back_idle (back_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/tli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tli_front.sv -----
// Front end: accepts requests, writes table loads, queues classified queries.
// Depends on tli_pkg.
module tli_front #(
  parameter int TABLE_DEPTH = 64,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tli_pkg::tli_in_t    in_data,
  input  logic                mode_one_dim,
  input  logic                back_idle,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [63:0]         ram_wdata,
  output logic                job_valid,
  input  logic                job_ready,
  output tli_pkg::tli_job_t   job
);
  import tli_pkg::*;

  tli_job_t   q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       is_query, accept, push, pop;
  tli_job_t   new_job;

  // Loads wait until every earlier query has finished with the table
  assign is_query = (in_data.action == ACT_QUERY);
  assign in_ready = is_query ? (cnt_r != 2'd2) : (cnt_r == 2'd0 && back_idle);
  assign accept   = in_valid && in_ready;
  assign push     = accept && is_query;
  assign pop      = job_valid && job_ready;

  // Table write
  assign ram_we    = accept && !is_query && (int'(in_data.entry_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(in_data.entry_index);
  assign ram_wdata = {in_data.entry_distance, in_data.entry_redshift};

  // Classify: mode off or non-positive position answers zero
  always_comb begin
    new_job.position   = in_data.position;
    new_job.force_zero = !mode_one_dim || in_data.position[31] || (in_data.position == '0);
  end

  // Two-entry query queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_job;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_query |-> cnt_r == 2'd0 && back_idle)
    else $error("load accepted with queries outstanding");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count missed a push");
`endif

endmodule

// ----- rtl/tli_div.sv -----
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// No dependencies.
module tli_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] sh_r;
  logic [31:0] rem_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial, rem_sh;
  logic        qbit;

  assign rem_sh = {rem_r, sh_r[63]};
  assign trial  = rem_sh - {1'b0, dvs_r};
  assign qbit   = !trial[32];

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= {sh_r[62:0], qbit};
      rem_r <= qbit ? trial[31:0] : rem_sh[31:0];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

// ----- rtl/tli_back.sv -----
// Back end: scans the table for the segment, interpolates, holds the result.
// Depends on tli_pkg, tli_div.
module tli_back #(
  parameter int TABLE_DEPTH = 64,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int KW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  tli_pkg::tli_job_t  job,
  input  logic [KW-1:0]      n_cnt,
  output logic [AW-1:0]      ram_raddr,
  input  logic [63:0]        ram_rdata,
  output logic               back_idle,
  output logic               out_valid,
  input  logic               out_ready,
  output tli_pkg::tli_out_t  out_data
);
  import tli_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIRST, ST_RD, ST_CHK, ST_PREP, ST_MUL, ST_DSTART, ST_DIV, ST_FIN, ST_PUT
  } state_t;

  state_t             state_r;
  logic [KW-1:0]      k_r;
  logic signed [31:0] pos_r, d0_r, d1_r;
  logic [31:0]        r0_r, r1_r;
  logic [31:0]        udiff_r, uoff_r, uden_r;
  logic               neg_r;
  logic [63:0]        prod_r;
  tli_out_t           res_r, out_data_r;
  logic               out_valid_r;
  logic               div_start, div_done;
  logic [63:0]        div_q;
  logic               put_fire;

  logic signed [32:0] den, diff, off;
  logic [33:0]        mag;
  logic [34:0]        sum;
  logic               trivial;

  // Segment arithmetic on the two bracketing entries
  always_comb begin
    den  = {d1_r[31], d1_r} - {d0_r[31], d0_r};
    diff = {1'b0, r1_r} - {1'b0, r0_r};
    off  = {pos_r[31], pos_r} - {d0_r[31], d0_r};
    trivial = den[32] || (den == '0) || (diff == '0) || (off == '0);
  end

  // Saturate quotient and apply to the base redshift
  always_comb begin
    mag = (div_q > 64'h2_0000_0000) ? 34'h2_0000_0000 : div_q[33:0];
    sum = neg_r ? ({3'b0, r0_r} - {1'b0, mag}) : ({3'b0, r0_r} + {1'b0, mag});
  end

  assign ram_raddr = (state_r == ST_RD) ? k_r[AW-1:0] : '0;
  assign job_ready = (state_r == ST_IDLE);
  assign back_idle = (state_r == ST_IDLE);
  assign div_start = (state_r == ST_DSTART);
  // Result moves to the output register when that register is free or draining
  assign put_fire  = (state_r == ST_PUT) && (!out_valid_r || out_ready);

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (uden_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (put_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            pos_r <= job.position;
            if (job.force_zero) begin
              res_r   <= '0;
              state_r <= ST_PUT;
            end else begin
              state_r <= ST_FIRST;
            end
          end
        end
        ST_FIRST: begin
          {d0_r, r0_r} <= ram_rdata;
          k_r          <= KW'(1);
          state_r      <= ST_RD;
        end
        ST_RD: begin
          if (k_r >= n_cnt) begin
            res_r.redshift     <= r0_r;
            res_r.beyond_table <= 1'b1;
            state_r            <= ST_PUT;
          end else begin
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if ($signed(ram_rdata[63:32]) <= pos_r) begin
            {d0_r, r0_r} <= ram_rdata;
            k_r          <= k_r + KW'(1);
            state_r      <= ST_RD;
          end else begin
            {d1_r, r1_r} <= ram_rdata;
            state_r      <= ST_PREP;
          end
        end
        ST_PREP: begin
          res_r.beyond_table <= 1'b0;
          if (trivial) begin
            res_r.redshift <= r0_r;
            state_r        <= ST_PUT;
          end else begin
            neg_r   <= diff[32] ^ off[32];
            udiff_r <= diff[32] ? 32'(-diff) : diff[31:0];
            uoff_r  <= off[32] ? 32'(-off) : off[31:0];
            uden_r  <= den[31:0];
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= 64'(udiff_r) * 64'(uoff_r);
          state_r <= ST_DSTART;
        end
        ST_DSTART: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_done) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (sum[34]) begin
            res_r.redshift <= '0;
          end else if (sum[33:32] != 2'b00) begin
            res_r.redshift <= '1;
          end else begin
            res_r.redshift <= sum[31:0];
          end
          state_r <= ST_PUT;
        end
        ST_PUT: begin
          if (put_fire) begin
            out_data_r <= res_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_CHK) |-> k_r <= n_cnt)
    else $error("scan ran past the entries in use");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");
  a_put: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUT && !out_valid_r |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not posted to free output register");
`endif

endmodule

// ----- test/table_linear_interpolator_tb.sv -----
// Self-checking testbench for the table linear interpolator.
// Needs tli_pkg and table_linear_interpolator from the rtl folder; reads nothing else.
`timescale 1ns / 1ps

module table_linear_interpolator_tb;
  import tli_pkg::*;

  localparam int DEPTH      = 64;
  localparam int SETTLE     = 120;
  localparam int WDOG_LIMIT = 5000;
  localparam int PHASES     = 14;

  typedef enum logic {K_REQ, K_CFG} item_kind_t;

  typedef struct {
    item_kind_t kind;
    bit         hold;    // wait for all answers before sending
    int         gap;
    tli_in_t    req;
    logic       cfg_i;
    logic [6:0] cfg_v;
  } item_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tli_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tli_out_t out_data;
  logic     cfg_wr_en = 1'b0;
  logic     cfg_index = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  item_t    pending_reqs[$];
  tli_out_t expected_results[$];
  int       errors = 0;

  // Predictor state
  int          p_dist[DEPTH];
  logic [31:0] p_red[DEPTH];
  logic        p_mode = 1'b1;
  logic [6:0]  p_count = 7'd2;

  // Generator's view of the table
  int  g_dist[DEPTH];
  bit  last_was_query = 0;
  int  phase_gap_max = 10;

  table_linear_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Exact interpolation with truncation toward zero, clamped to 32 bits
  function automatic logic [31:0] interp_redshift(logic [31:0] r0, logic [31:0] r1,
                                                  longint d0, longint d1, longint pos);
    longint den, diff, off, res;
    longint unsigned udiff, uoff, uden, a, b, mag;
    bit neg;
    den  = d1 - d0;
    diff = longint'(r1) - longint'(r0);
    off  = pos - d0;
    if (den <= 0 || diff == 0 || off == 0) return r0;
    neg   = (diff < 0) != (off < 0);
    udiff = (diff < 0) ? -diff : diff;
    uoff  = (off < 0) ? -off : off;
    uden  = den;
    a = uoff / uden;
    b = uoff % uden;
    if (a > 64'h1_0000_0000) begin
      mag = 64'h2_0000_0000;
    end else begin
      mag = udiff * a;
      if (mag > 64'h2_0000_0000) mag = 64'h2_0000_0000;
      mag += (udiff * b) / uden;
      if (mag > 64'h2_0000_0000) mag = 64'h2_0000_0000;
    end
    res = neg ? longint'(r0) - longint'(mag) : longint'(r0) + longint'(mag);
    if (res < 0) return 32'd0;
    if (res > 64'sh0_FFFF_FFFF) return 32'hFFFF_FFFF;
    return res[31:0];
  endfunction

  function automatic int eff_count(logic [6:0] c);
    if (c < 2) return 2;
    if (c > DEPTH) return DEPTH;
    return int'(c);
  endfunction

  function automatic tli_out_t predict_redshift(logic signed [31:0] pos);
    tli_out_t r;
    int n, i;
    r = '0;
    if (!p_mode || pos <= 0) return r;
    n = eff_count(p_count);
    i = 0;
    while (i + 1 < n && p_dist[i+1] <= pos) i++;
    if (i + 1 >= n) begin
      r.redshift = p_red[n-1];
      r.beyond_table = 1'b1;
      return r;
    end
    r.redshift = interp_redshift(p_red[i], p_red[i+1], p_dist[i], p_dist[i+1], pos);
    return r;
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic int draw_gap();
    return $urandom_range(0, phase_gap_max);
  endfunction

  function automatic tli_in_t noise_fields();
    tli_in_t r;
    r.action = ACT_LOAD;
    r.entry_index = 6'($urandom);
    r.entry_distance = $urandom;
    r.entry_redshift = $urandom;
    r.position = $urandom;
    return r;
  endfunction

  task automatic add_load(int idx, int dist_v, logic [31:0] red);
    item_t it;
    it.kind = K_REQ;
    it.hold = last_was_query;
    it.gap = draw_gap();
    it.req = noise_fields();
    it.req.action = ACT_LOAD;
    it.req.entry_index = 6'(idx);
    it.req.entry_distance = dist_v;
    it.req.entry_redshift = red;
    it.cfg_i = CFG_MODE;
    it.cfg_v = '0;
    pending_reqs.push_back(it);
    g_dist[idx] = dist_v;
    last_was_query = 0;
  endtask

  task automatic add_query(int pos);
    item_t it;
    it.kind = K_REQ;
    it.hold = 0;
    it.gap = draw_gap();
    it.req = noise_fields();
    it.req.action = ACT_QUERY;
    it.req.position = pos;
    it.cfg_i = CFG_MODE;
    it.cfg_v = '0;
    pending_reqs.push_back(it);
    last_was_query = 1;
  endtask

  task automatic add_cfg(logic idx, logic [6:0] val);
    item_t it;
    it.kind = K_CFG;
    it.hold = 1;
    it.gap = 0;
    it.req = '0;
    it.cfg_i = idx;
    it.cfg_v = val;
    pending_reqs.push_back(it);
  endtask

  // Rewrite all entries; mostly rising, sometimes flat or falling steps
  task automatic build_table();
    longint d;
    logic [31:0] red;
    int style;
    style = $urandom_range(0, 3);
    case (style)
      0: d = longint'($urandom_range(0, 1000));
      1: d = int'($urandom);
      default: d = -longint'($urandom_range(0, 5000));
    endcase
    red = $urandom;
    for (int i = 0; i < DEPTH; i++) begin
      if ($urandom_range(0, 2) == 0) red = $urandom;
      else red = red + $urandom_range(0, 32'h0100_0000);
      add_load(i, int'(d), red);
      if ($urandom_range(0, 15) == 0) d = d - longint'($urandom_range(0, 50));
      else if (style == 1 || $urandom_range(0, 3) == 0)
        d = d + longint'($urandom_range(1, 1 << 25));
      else d = d + longint'($urandom_range(1, 1000));
    end
  endtask

  function automatic int pick_position(int n);
    longint lo, hi;
    int i;
    case ($urandom_range(0, 9))
      0: return int'($urandom);
      1: return g_dist[$urandom_range(0, n - 1)];
      2: return g_dist[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      3: return g_dist[n-1] + int'($urandom_range(0, 100));
      default: begin
        i = $urandom_range(0, n - 2);
        lo = g_dist[i];
        hi = g_dist[i+1];
        if (hi > lo) return int'(lo + longint'($urandom % (hi - lo)));
        return int'(lo);
      end
    endcase
  endfunction

  // ---------------- driver ----------------
  bit          n_valid, n_cfg;
  tli_in_t     n_data;
  logic        n_cfg_i;
  logic [6:0]  n_cfg_v;
  int          gap_left = 0;
  int          settle = SETTLE;
  item_t       cur;

  always @(posedge clk) begin
    n_valid = in_valid && !in_ready;
    n_data  = in_data;
    n_cfg   = 0;
    n_cfg_i = cfg_index;
    n_cfg_v = cfg_wdata;
    if (!rst_n) begin
      n_valid = 0;
    end else begin
      // Update predictor with the request taken at this edge
      if (in_valid && in_ready) begin
        if (in_data.action == ACT_QUERY) begin
          expected_results.push_back(predict_redshift(in_data.position));
        end else begin
          p_dist[in_data.entry_index] = in_data.entry_distance;
          p_red[in_data.entry_index]  = in_data.entry_redshift;
        end
      end
      if (!n_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          if (pending_reqs[0].hold &&
              (expected_results.size() != 0 || (in_valid && in_ready))) begin
            settle = SETTLE;
          end else if (pending_reqs[0].hold && settle > 0) begin
            settle--;
          end else begin
            cur = pending_reqs.pop_front();
            settle = SETTLE;
            gap_left = cur.gap;
            if (cur.kind == K_CFG) begin
              n_cfg = 1;
              n_cfg_i = cur.cfg_i;
              n_cfg_v = cur.cfg_v;
              if (cur.cfg_i == CFG_MODE) p_mode = cur.cfg_v[0];
              else p_count = cur.cfg_v;
            end else begin
              n_valid = 1;
              n_data = cur.req;
            end
          end
        end
      end
    end
    in_valid  <= n_valid;
    in_data   <= n_data;
    cfg_wr_en <= n_cfg;
    cfg_index <= n_cfg_i;
    cfg_wdata <= n_cfg_v;
  end

  // ---------------- monitor ----------------
  int       stall = 0;
  tli_out_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      stall = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: redshift %h beyond_table %b",
                 out_data.redshift, out_data.beyond_table);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.redshift !== want.redshift) begin
            $error("redshift: expected %h, got %h", want.redshift, out_data.redshift);
            errors++;
          end
          if (out_data.beyond_table !== want.beyond_table) begin
            $error("beyond_table: expected %b, got %b",
                   want.beyond_table, out_data.beyond_table);
            errors++;
          end
        end
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------
  int n;

  initial begin
    // Directed: two-entry table at reset settings
    add_load(0, 100, 32'h0100_0000);
    add_load(1, 1100, 32'h0300_0000);
    add_query(0);
    add_query(-1);
    add_query(-2147483648);
    add_query(1);
    add_query(50);
    add_query(600);
    add_query(1099);
    add_query(1100);
    add_query(2147483647);
    // Mode off forces zero
    add_cfg(CFG_MODE, 7'd0);
    add_query(600);
    add_cfg(CFG_MODE, 7'd1);
    // Falling redshift, extrapolation clamped at the top
    add_load(0, 100, 32'hFFFF_FFFF);
    add_load(1, 1100, 32'h0);
    add_query(50);
    add_query(1099);
    // Zero-width segment: both entries at the same distance
    add_load(1, 100, 32'h1234_5678);
    add_query(50);
    add_query(200);

    // Random phases
    for (int ph = 0; ph < PHASES; ph++) begin
      phase_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      build_table();
      case ($urandom_range(0, 7))
        0: add_cfg(CFG_COUNT, 7'd64);
        1: add_cfg(CFG_COUNT, 7'($urandom_range(0, 1)));
        2: add_cfg(CFG_COUNT, 7'($urandom_range(65, 127)));
        3: add_cfg(CFG_COUNT, 7'($urandom_range(2, 64)));
        default: add_cfg(CFG_COUNT, 7'($urandom_range(2, 8)));
      endcase
      if (ph == 0) add_cfg(CFG_COUNT, 7'd127);
      add_cfg(CFG_MODE, ($urandom_range(0, 7) == 0) ? 7'd0 : 7'd1);
      n = eff_count(pending_reqs[$].kind == K_CFG && pending_reqs[$-1].kind == K_CFG ?
                    pending_reqs[$-1].cfg_v : 7'd2);
      for (int q = 0; q < 60; q++) begin
        if ($urandom_range(0, 24) == 0)
          add_load($urandom_range(0, DEPTH - 1), int'($urandom), $urandom);
        else
          add_query(pick_position(n));
      end
    end
    add_cfg(CFG_MODE, 7'd1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (250) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
